@@ design/rfcs_pkg.sv @@
// ----------------------------------------------------------------------------
// rfcs_pkg
// Shared types and constants for the ROI frame change statistics unit.
// ----------------------------------------------------------------------------
package rfcs_pkg;

    localparam int MAX_DIM   = 4096;
    localparam int POS_W     = 12;
    localparam int DIM_W     = 13;
    localparam int PIX_W     = 8;
    localparam int THR_W     = 9;
    localparam int CNT_W     = 25;
    localparam int SUM_W     = 33;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 13;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DELTA_THRESHOLD = 3'd0,
        REG_FRAME_WIDTH     = 3'd1,
        REG_FRAME_HEIGHT    = 3'd2,
        REG_ROI_LEFT        = 3'd3,
        REG_ROI_TOP         = 3'd4,
        REG_ROI_SPAN_X      = 3'd5,
        REG_ROI_SPAN_Y      = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic [DIM_W-1:0] x0;
        logic [DIM_W-1:0] y0;
        logic [DIM_W-1:0] x1;
        logic [DIM_W-1:0] y1;
    } region_t;

    typedef struct packed {
        logic [PIX_W-1:0] before_pix;
        logic [PIX_W-1:0] after_pix;
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] row;
        logic             last;
    } pixel_item_t;

    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = DIM_W'(1);
        else if (v > DIM_W'(MAX_DIM))
            r = DIM_W'(MAX_DIM);
        else
            r = v;
        return r;
    endfunction

endpackage

@@ design/rfcs_config.sv @@
// ----------------------------------------------------------------------------
// rfcs_config
// Configuration registers and resolution of the effective frame size and ROI.
// ----------------------------------------------------------------------------
module rfcs_config
    import rfcs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    output logic [THR_W-1:0]     threshold,
    output logic [DIM_W-1:0]     eff_width,
    output logic [DIM_W-1:0]     eff_height,
    output region_t              region
);

    logic [THR_W-1:0] thr_reg;
    logic [DIM_W-1:0] fw_reg;
    logic [DIM_W-1:0] fh_reg;
    logic [POS_W-1:0] left_reg;
    logic [POS_W-1:0] top_reg;
    logic [DIM_W-1:0] span_x_reg;
    logic [DIM_W-1:0] span_y_reg;

    logic [DIM_W:0]   x1_sum;
    logic [DIM_W:0]   y1_sum;
    logic [DIM_W-1:0] x0_c;
    logic [DIM_W-1:0] y0_c;
    logic [DIM_W-1:0] x1_c;
    logic [DIM_W-1:0] y1_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg    <= THR_W'(16);
            fw_reg     <= DIM_W'(640);
            fh_reg     <= DIM_W'(480);
            left_reg   <= '0;
            top_reg    <= '0;
            span_x_reg <= '0;
            span_y_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_DELTA_THRESHOLD: thr_reg    <= cfg_data[THR_W-1:0];
                REG_FRAME_WIDTH:     fw_reg     <= cfg_data;
                REG_FRAME_HEIGHT:    fh_reg     <= cfg_data;
                REG_ROI_LEFT:        left_reg   <= cfg_data[POS_W-1:0];
                REG_ROI_TOP:         top_reg    <= cfg_data[POS_W-1:0];
                REG_ROI_SPAN_X:      span_x_reg <= cfg_data;
                REG_ROI_SPAN_Y:      span_y_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign threshold  = thr_reg;
    assign eff_width  = eff_dim(fw_reg);
    assign eff_height = eff_dim(fh_reg);

    always_comb
    begin
        x1_sum = {2'b00, left_reg} + {1'b0, span_x_reg};
        y1_sum = {2'b00, top_reg} + {1'b0, span_y_reg};
        x0_c   = ({1'b0, left_reg} > eff_width) ? eff_width : {1'b0, left_reg};
        y0_c   = ({1'b0, top_reg} > eff_height) ? eff_height : {1'b0, top_reg};
        x1_c   = (x1_sum > {1'b0, eff_width}) ? eff_width : x1_sum[DIM_W-1:0];
        y1_c   = (y1_sum > {1'b0, eff_height}) ? eff_height : y1_sum[DIM_W-1:0];
        region.x0 = '0;
        region.y0 = '0;
        region.x1 = eff_width;
        region.y1 = eff_height;
        if (span_x_reg != '0 && span_y_reg != '0 && x1_c > x0_c && y1_c > y0_c)
        begin
            region.x0 = x0_c;
            region.y0 = y0_c;
            region.x1 = x1_c;
            region.y1 = y1_c;
        end
    end

endmodule

@@ design/rfcs_scan.sv @@
// ----------------------------------------------------------------------------
// rfcs_scan
// Raster position counters and the input register stage.
// ----------------------------------------------------------------------------
module rfcs_scan
    import rfcs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [PIX_W-1:0] before_pixel,
    input  logic [PIX_W-1:0] after_pixel,
    input  logic [DIM_W-1:0] eff_width,
    input  logic [DIM_W-1:0] eff_height,
    input  logic             item_take,
    output logic             item_valid,
    output pixel_item_t      item
);

    logic [POS_W-1:0] col_reg;
    logic [POS_W-1:0] col_next;
    logic [POS_W-1:0] row_reg;
    logic [POS_W-1:0] row_next;
    logic             valid_reg;
    logic             valid_next;
    pixel_item_t      item_reg;
    pixel_item_t      item_next;
    logic             accept;
    logic             end_col;
    logic             end_row;
    logic [DIM_W-1:0] col_inc;
    logic [DIM_W-1:0] row_inc;

    assign in_stall = valid_reg && !item_take;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        col_inc = {1'b0, col_reg} + DIM_W'(1);
        row_inc = {1'b0, row_reg} + DIM_W'(1);
        end_col = col_inc >= eff_width;
        end_row = row_inc >= eff_height;
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (end_col)
            begin
                col_next = '0;
                row_next = end_row ? '0 : row_inc[POS_W-1:0];
            end
            else
            begin
                col_next = col_inc[POS_W-1:0];
            end
        end
        valid_next = accept ? 1'b1 : (item_take ? 1'b0 : valid_reg);
        item_next.before_pix = before_pixel;
        item_next.after_pix  = after_pixel;
        item_next.col        = col_reg;
        item_next.row        = row_reg;
        item_next.last       = end_col && end_row;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= item_next;
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

@@ design/rfcs_stats.sv @@
// ----------------------------------------------------------------------------
// rfcs_stats
// Per-pixel change test, frame accumulators, bounding box and result register.
// ----------------------------------------------------------------------------
module rfcs_stats
    import rfcs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    input  pixel_item_t      item,
    output logic             item_take,
    input  logic [THR_W-1:0] threshold,
    input  region_t          region,
    output logic             out_valid,
    input  logic             out_stall,
    output logic             mask_bit,
    output logic             in_roi,
    output logic             frame_done,
    output logic             motion_flag,
    output logic [CNT_W-1:0] changed_count,
    output logic [CNT_W-1:0] darker_count,
    output logic [CNT_W-1:0] brighter_count,
    output logic [SUM_W-1:0] delta_total,
    output logic [POS_W-1:0] box_x,
    output logic [POS_W-1:0] box_y,
    output logic [DIM_W-1:0] box_width,
    output logic [DIM_W-1:0] box_height
);

    logic [CNT_W-1:0] chg_reg, chg_next, chg_upd;
    logic [CNT_W-1:0] dark_reg, dark_next, dark_upd;
    logic [CNT_W-1:0] bright_reg, bright_next, bright_upd;
    logic [SUM_W-1:0] sum_reg, sum_next, sum_upd;
    logic [POS_W-1:0] lc_reg, lc_next;
    logic [POS_W-1:0] lr_reg, lr_next;
    logic [POS_W-1:0] gc_reg, gc_next;
    logic [POS_W-1:0] gr_reg, gr_next;
    logic             out_valid_reg, out_valid_next;

    logic             mask_reg, mask_next;
    logic             inr_reg, inr_next;
    logic             done_reg, done_next;
    logic             motion_reg, motion_next;
    logic [CNT_W-1:0] ocnt_reg, ocnt_next;
    logic [CNT_W-1:0] odark_reg, odark_next;
    logic [CNT_W-1:0] obright_reg, obright_next;
    logic [SUM_W-1:0] osum_reg, osum_next;
    logic [POS_W-1:0] bx_reg, bx_next;
    logic [POS_W-1:0] by_reg, by_next;
    logic [DIM_W-1:0] bw_reg, bw_next;
    logic [DIM_W-1:0] bh_reg, bh_next;

    logic signed [PIX_W:0] delta;
    logic [PIX_W:0]        mag;
    logic [DIM_W-1:0]      col_w;
    logic [DIM_W-1:0]      row_w;
    logic                  inr;
    logic                  changed;
    logic                  first;

    assign item_take = item_valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        delta   = $signed({1'b0, item.after_pix}) - $signed({1'b0, item.before_pix});
        mag     = delta[PIX_W] ? (PIX_W + 1)'(-delta) : (PIX_W + 1)'(delta);
        col_w   = {1'b0, item.col};
        row_w   = {1'b0, item.row};
        inr     = col_w >= region.x0 && col_w < region.x1
               && row_w >= region.y0 && row_w < region.y1;
        changed = inr && (mag >= threshold);
        first   = chg_reg == '0;

        chg_upd    = chg_reg;
        dark_upd   = dark_reg;
        bright_upd = bright_reg;
        sum_upd    = sum_reg;
        lc_next    = lc_reg;
        lr_next    = lr_reg;
        gc_next    = gc_reg;
        gr_next    = gr_reg;
        if (changed)
        begin
            chg_upd = chg_reg + CNT_W'(1);
            sum_upd = sum_reg + {{(SUM_W - PIX_W - 1){delta[PIX_W]}}, delta};
            if (delta[PIX_W])
                dark_upd = dark_reg + CNT_W'(1);
            else
                bright_upd = bright_reg + CNT_W'(1);
            if (first)
            begin
                lc_next = item.col;
                gc_next = item.col;
                lr_next = item.row;
                gr_next = item.row;
            end
            else
            begin
                if (item.col < lc_reg)
                    lc_next = item.col;
                if (item.col > gc_reg)
                    gc_next = item.col;
                if (item.row < lr_reg)
                    lr_next = item.row;
                if (item.row > gr_reg)
                    gr_next = item.row;
            end
        end

        if (item.last)
        begin
            chg_next    = '0;
            dark_next   = '0;
            bright_next = '0;
            sum_next    = '0;
        end
        else
        begin
            chg_next    = chg_upd;
            dark_next   = dark_upd;
            bright_next = bright_upd;
            sum_next    = sum_upd;
        end

        mask_next    = changed;
        inr_next     = inr;
        done_next    = item.last;
        motion_next  = 1'b0;
        ocnt_next    = '0;
        odark_next   = '0;
        obright_next = '0;
        osum_next    = '0;
        bx_next      = '0;
        by_next      = '0;
        bw_next      = '0;
        bh_next      = '0;
        if (item.last)
        begin
            motion_next  = chg_upd != '0;
            ocnt_next    = chg_upd;
            odark_next   = dark_upd;
            obright_next = bright_upd;
            osum_next    = sum_upd;
            if (chg_upd != '0)
            begin
                bx_next = lc_next;
                by_next = lr_next;
                bw_next = {1'b0, gc_next} - {1'b0, lc_next} + DIM_W'(1);
                bh_next = {1'b0, gr_next} - {1'b0, lr_next} + DIM_W'(1);
            end
            else
            begin
                bx_next = region.x0[POS_W-1:0];
                by_next = region.y0[POS_W-1:0];
                bw_next = region.x1 - region.x0;
                bh_next = region.y1 - region.y0;
            end
        end

        out_valid_next = item_take ? 1'b1 : (out_stall ? out_valid_reg : 1'b0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chg_reg       <= '0;
            dark_reg      <= '0;
            bright_reg    <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (item_take)
            begin
                chg_reg    <= chg_next;
                dark_reg   <= dark_next;
                bright_reg <= bright_next;
                sum_reg    <= sum_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            lc_reg      <= lc_next;
            lr_reg      <= lr_next;
            gc_reg      <= gc_next;
            gr_reg      <= gr_next;
            mask_reg    <= mask_next;
            inr_reg     <= inr_next;
            done_reg    <= done_next;
            motion_reg  <= motion_next;
            ocnt_reg    <= ocnt_next;
            odark_reg   <= odark_next;
            obright_reg <= obright_next;
            osum_reg    <= osum_next;
            bx_reg      <= bx_next;
            by_reg      <= by_next;
            bw_reg      <= bw_next;
            bh_reg      <= bh_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign mask_bit       = mask_reg;
    assign in_roi         = inr_reg;
    assign frame_done     = done_reg;
    assign motion_flag    = motion_reg;
    assign changed_count  = ocnt_reg;
    assign darker_count   = odark_reg;
    assign brighter_count = obright_reg;
    assign delta_total    = osum_reg;
    assign box_x          = bx_reg;
    assign box_y          = by_reg;
    assign box_width      = bw_reg;
    assign box_height     = bh_reg;

endmodule

@@ design/roi_frame_change_statistics_unit.sv @@
// ----------------------------------------------------------------------------
// roi_frame_change_statistics_unit
// Frame difference motion statistics over a region of interest.
// ----------------------------------------------------------------------------
// Pixel pairs stream in raster order, one transaction per clock while
// in_stall is low; the unit tracks column and row itself. Every pixel
// yields one result transaction, held first in the input register and
// then in the result register. The last pixel of a frame also carries the
// frame totals and the change bounding box, after which the statistics
// clear. A waiting result does not block the next pixel: the input
// register keeps taking data until both stages are full. Write
// configuration only while no transaction is in flight.
module roi_frame_change_statistics_unit
    import rfcs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [PIX_W-1:0]     before_pixel,
    input  logic [PIX_W-1:0]     after_pixel,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 mask_bit,
    output logic                 in_roi,
    output logic                 frame_done,
    output logic                 motion_flag,
    output logic [CNT_W-1:0]     changed_count,
    output logic [CNT_W-1:0]     darker_count,
    output logic [CNT_W-1:0]     brighter_count,
    output logic [SUM_W-1:0]     delta_total,
    output logic [POS_W-1:0]     box_x,
    output logic [POS_W-1:0]     box_y,
    output logic [DIM_W-1:0]     box_width,
    output logic [DIM_W-1:0]     box_height
);

    logic [THR_W-1:0] threshold;
    logic [DIM_W-1:0] eff_width;
    logic [DIM_W-1:0] eff_height;
    region_t          region;
    logic             item_valid;
    logic             item_take;
    pixel_item_t      item;

    rfcs_config u_config (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .threshold  (threshold),
        .eff_width  (eff_width),
        .eff_height (eff_height),
        .region     (region)
    );

    rfcs_scan u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .before_pixel (before_pixel),
        .after_pixel  (after_pixel),
        .eff_width    (eff_width),
        .eff_height   (eff_height),
        .item_take    (item_take),
        .item_valid   (item_valid),
        .item         (item)
    );

    rfcs_stats u_stats (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item           (item),
        .item_take      (item_take),
        .threshold      (threshold),
        .region         (region),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .mask_bit       (mask_bit),
        .in_roi         (in_roi),
        .frame_done     (frame_done),
        .motion_flag    (motion_flag),
        .changed_count  (changed_count),
        .darker_count   (darker_count),
        .brighter_count (brighter_count),
        .delta_total    (delta_total),
        .box_x          (box_x),
        .box_y          (box_y),
        .box_width      (box_width),
        .box_height     (box_height)
    );

`ifndef SYNTHESIS
    a_mask_in_roi: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && mask_bit |-> in_roi)
        else $error("mask bit set outside roi");

    a_summary_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !frame_done |-> !motion_flag && changed_count == '0
            && delta_total == '0 && box_width == '0)
        else $error("summary fields set off frame end");

    a_count_split: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_done |-> changed_count == darker_count + brighter_count)
        else $error("darker and brighter counts do not add up");

    a_motion_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_done |-> motion_flag == (changed_count != '0))
        else $error("motion flag disagrees with changed count");
`endif

endmodule

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ROI frame change statistics unit. A pixel
// stream runs through the unit under several register settings while both
// sides idle and stall at random. Every result transaction is compared field
// by field with a cycle-free model of the unit kept in this bench.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rfcs_pkg::*;

    localparam int LATENCY     = 2;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 60;
    localparam int MAX_REPORTS = 10;

    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

    typedef struct packed {
        logic             mask;
        logic             in_region;
        logic             done;
        logic             motion;
        logic [CNT_W-1:0] changed;
        logic [CNT_W-1:0] darker;
        logic [CNT_W-1:0] brighter;
        logic [SUM_W-1:0] sum;
        logic [POS_W-1:0] bx;
        logic [POS_W-1:0] by;
        logic [DIM_W-1:0] bw;
        logic [DIM_W-1:0] bh;
    } pixel_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [PIX_W-1:0]     before_pixel = '0;
    logic [PIX_W-1:0]     after_pixel = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic                 mask_bit;
    logic                 in_roi;
    logic                 frame_done;
    logic                 motion_flag;
    logic [CNT_W-1:0]     changed_count;
    logic [CNT_W-1:0]     darker_count;
    logic [CNT_W-1:0]     brighter_count;
    logic [SUM_W-1:0]     delta_total;
    logic [POS_W-1:0]     box_x;
    logic [POS_W-1:0]     box_y;
    logic [DIM_W-1:0]     box_width;
    logic [DIM_W-1:0]     box_height;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatch_count = 0;
    int cycle_count = 0;
    logic hold_request = 1'b0;
    logic hold_done = 1'b0;
    int hold_left = 0;

    pixel_result_t pending_results[$];

    // register copies
    int thr_q, frame_w_q, frame_h_q, roi_x_q, roi_y_q, span_x_q, span_y_q;
    // frame state
    int col_pos, row_pos, n_changed, n_darker, n_brighter;
    longint diff_sum;
    int lo_x, lo_y, hi_x, hi_y;

    roi_frame_change_statistics_unit DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .before_pixel   (before_pixel),
        .after_pixel    (after_pixel),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .mask_bit       (mask_bit),
        .in_roi         (in_roi),
        .frame_done     (frame_done),
        .motion_flag    (motion_flag),
        .changed_count  (changed_count),
        .darker_count   (darker_count),
        .brighter_count (brighter_count),
        .delta_total    (delta_total),
        .box_x          (box_x),
        .box_y          (box_y),
        .box_width      (box_width),
        .box_height     (box_height)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // long receiver hold-off
    always @(posedge clk)
    begin
        if (hold_request && !hold_done)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
    end

    function automatic int dim_of(input int v);
        if (v == 0)
            return 1;
        if (v > MAX_DIM)
            return MAX_DIM;
        return v;
    endfunction

    function automatic void find_region(output int x0, output int y0, output int x1,
                                        output int y1);
        int w, h, cx0, cy0, cx1, cy1;
        w = dim_of(frame_w_q);
        h = dim_of(frame_h_q);
        x0 = 0;
        y0 = 0;
        x1 = w;
        y1 = h;
        if (span_x_q != 0 && span_y_q != 0)
        begin
            cx0 = (roi_x_q > w) ? w : roi_x_q;
            cy0 = (roi_y_q > h) ? h : roi_y_q;
            cx1 = (roi_x_q + span_x_q > w) ? w : roi_x_q + span_x_q;
            cy1 = (roi_y_q + span_y_q > h) ? h : roi_y_q + span_y_q;
            if (cx1 > cx0 && cy1 > cy0)
            begin
                x0 = cx0;
                y0 = cy0;
                x1 = cx1;
                y1 = cy1;
            end
        end
    endfunction

    function automatic void clear_frame_stats();
        int x0, y0, x1, y1;
        find_region(x0, y0, x1, y1);
        n_changed = 0;
        n_darker = 0;
        n_brighter = 0;
        diff_sum = 0;
        lo_x = x1;
        lo_y = y1;
        hi_x = -1;
        hi_y = -1;
    endfunction

    task automatic reset_model();
        thr_q = 16;
        frame_w_q = 640;
        frame_h_q = 480;
        roi_x_q = 0;
        roi_y_q = 0;
        span_x_q = 0;
        span_y_q = 0;
        col_pos = 0;
        row_pos = 0;
        clear_frame_stats();
    endtask

    function automatic pixel_result_t predict_pixel(input logic [PIX_W-1:0] b,
                                                    input logic [PIX_W-1:0] a);
        pixel_result_t r;
        int w, h, x0, y0, x1, y1, diff, mag;
        bit in_region, hit, last;
        w = dim_of(frame_w_q);
        h = dim_of(frame_h_q);
        find_region(x0, y0, x1, y1);
        diff = int'(a) - int'(b);
        mag = (diff < 0) ? -diff : diff;
        in_region = col_pos >= x0 && col_pos < x1 && row_pos >= y0 && row_pos < y1;
        hit = in_region && mag >= thr_q;
        if (hit)
        begin
            if (n_changed == 0)
            begin
                lo_x = col_pos;
                hi_x = col_pos;
                lo_y = row_pos;
                hi_y = row_pos;
            end
            else
            begin
                if (col_pos < lo_x) lo_x = col_pos;
                if (col_pos > hi_x) hi_x = col_pos;
                if (row_pos < lo_y) lo_y = row_pos;
                if (row_pos > hi_y) hi_y = row_pos;
            end
            n_changed++;
            diff_sum += diff;
            if (diff < 0)
                n_darker++;
            else
                n_brighter++;
        end
        last = (col_pos + 1 >= w) && (row_pos + 1 >= h);
        r = '0;
        r.mask = hit;
        r.in_region = in_region;
        if (last)
        begin
            r.done = 1'b1;
            r.motion = (n_changed != 0);
            r.changed = CNT_W'(n_changed);
            r.darker = CNT_W'(n_darker);
            r.brighter = CNT_W'(n_brighter);
            r.sum = SUM_W'(diff_sum);
            if (n_changed != 0)
            begin
                r.bx = POS_W'(lo_x);
                r.by = POS_W'(lo_y);
                r.bw = DIM_W'(hi_x - lo_x + 1);
                r.bh = DIM_W'(hi_y - lo_y + 1);
            end
            else
            begin
                r.bx = POS_W'(x0);
                r.by = POS_W'(y0);
                r.bw = DIM_W'(x1 - x0);
                r.bh = DIM_W'(y1 - y0);
            end
        end
        if (col_pos + 1 >= w)
        begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
        end
        else
        begin
            col_pos++;
        end
        if (last)
            clear_frame_stats();
        return r;
    endfunction

    function automatic int pixels_to_frame_end();
        int w, h, c, r, n;
        w = dim_of(frame_w_q);
        h = dim_of(frame_h_q);
        c = col_pos;
        r = row_pos;
        n = 1;
        while (!(c + 1 >= w && r + 1 >= h))
        begin
            if (c + 1 >= w)
            begin
                c = 0;
                r++;
            end
            else
            begin
                c++;
            end
            n++;
        end
        return n;
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned want,
                                   input longint unsigned got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("mismatch in %s at cycle %0d: expected %0h, actual %0h",
                     what, cycle_count, want, got);
    endtask

    task automatic check_field(input string what, input longint unsigned want,
                               input longint unsigned got);
        if (want != got)
            report_mismatch(what, want, got);
    endtask

    always @(posedge clk)
    begin : result_check
        pixel_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected transaction", 0, 1);
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("mask_bit", want.mask, mask_bit);
                check_field("in_roi", want.in_region, in_roi);
                check_field("frame_done", want.done, frame_done);
                check_field("motion_flag", want.motion, motion_flag);
                check_field("changed_count", want.changed, changed_count);
                check_field("darker_count", want.darker, darker_count);
                check_field("brighter_count", want.brighter, brighter_count);
                check_field("delta_total", want.sum, delta_total);
                check_field("box_x", want.bx, box_x);
                check_field("box_y", want.by, box_y);
                check_field("box_width", want.bw, box_width);
                check_field("box_height", want.bh, box_height);
            end
        end
    end

    task automatic send_pixel(input logic [PIX_W-1:0] b, input logic [PIX_W-1:0] a);
        pixel_result_t r;
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        before_pixel <= b;
        after_pixel <= a;
        do
            @(posedge clk);
        while (in_stall);
        r = predict_pixel(b, a);
        pending_results = {pending_results, r};
    endtask

    task automatic send_random_pixel();
        int b, a, t;
        b = $urandom_range(255);
        t = (thr_q > 300) ? 300 : thr_q;
        case ($urandom_range(7))
            0: a = b + t;
            1: a = b - t;
            2: a = b + t - 1;
            3: a = b - t + 1;
            4:
            begin
                b = $urandom_range(1) ? 255 : 0;
                a = 255 - b;
            end
            default: a = $urandom_range(255);
        endcase
        if (a < 0) a = 0;
        if (a > 255) a = 255;
        send_pixel(PIX_W'(b), PIX_W'(a));
    endtask

    // drain all transactions in flight
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        case (idx)
            REG_DELTA_THRESHOLD: thr_q = int'(data[THR_W-1:0]);
            REG_FRAME_WIDTH:     frame_w_q = int'(data);
            REG_FRAME_HEIGHT:    frame_h_q = int'(data);
            REG_ROI_LEFT:        roi_x_q = int'(data[POS_W-1:0]);
            REG_ROI_TOP:         roi_y_q = int'(data[POS_W-1:0]);
            REG_ROI_SPAN_X:      span_x_q = int'(data);
            REG_ROI_SPAN_Y:      span_y_q = int'(data);
            default: ;
        endcase
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input logic [CFG_DAT_W-1:0] thr, input logic [CFG_DAT_W-1:0] fw,
                             input logic [CFG_DAT_W-1:0] fh, input logic [CFG_DAT_W-1:0] rl,
                             input logic [CFG_DAT_W-1:0] rt, input logic [CFG_DAT_W-1:0] sx,
                             input logic [CFG_DAT_W-1:0] sy);
        write_reg(REG_DELTA_THRESHOLD, thr);
        write_reg(REG_FRAME_WIDTH, fw);
        write_reg(REG_FRAME_HEIGHT, fh);
        write_reg(REG_ROI_LEFT, rl);
        write_reg(REG_ROI_TOP, rt);
        write_reg(REG_ROI_SPAN_X, sx);
        write_reg(REG_ROI_SPAN_Y, sy);
    endtask

    task automatic randomize_config();
        logic [CFG_DAT_W-1:0] thr, fw, fh, rl, rt, sx, sy;
        case ($urandom_range(9))
            0: thr = '0;
            1: thr = 13'd256;
            2: thr = 13'h1FFF;
            3: thr = 13'($urandom_range(255));
            default: thr = 13'($urandom_range(1, 48));
        endcase
        fw = ($urandom_range(9) == 0) ? 13'd0 : 13'($urandom_range(1, 12));
        fh = ($urandom_range(9) == 0) ? 13'd0 : 13'($urandom_range(1, 6));
        rl = {1'($urandom_range(1)), 12'($urandom_range(0, 12))};
        rt = {1'($urandom_range(1)), 12'($urandom_range(0, 6))};
        sx = 13'($urandom_range(1, 12));
        sy = 13'($urandom_range(1, 6));
        case ($urandom_range(7))
            0: sx = '0;
            1: sy = '0;
            2:
            begin
                rl = {1'($urandom_range(1)), 12'($urandom_range(0, 4095))};
                rt = {1'($urandom_range(1)), 12'($urandom_range(0, 4095))};
            end
            3:
            begin
                rl = {1'($urandom_range(1)), 12'hFFF};
                sx = 13'h1FFF;
            end
            4:
            begin
                sx = 13'h1FFF;
                sy = 13'd4096;
            end
            default: ;
        endcase
        configure(thr, fw, fh, rl, rt, sx, sy);
    endtask

    task automatic test_reset_defaults();
        send_pixel(8'd0, 8'd15);
        send_pixel(8'd0, 8'd16);
        send_pixel(8'd255, 8'd239);
        send_pixel(8'd200, 8'd183);
        send_pixel(8'd77, 8'd77);
    endtask

    // one-pixel frames, so every transaction closes a frame
    task automatic test_threshold_extremes();
        settle();
        write_reg(REG_FRAME_WIDTH, 13'd0);
        write_reg(REG_FRAME_HEIGHT, 13'd0);
        send_pixel(8'd0, 8'd255);
        send_pixel(8'd255, 8'd0);
        settle();
        write_reg(REG_DELTA_THRESHOLD, 13'd0);
        send_pixel(8'd128, 8'd128);
        settle();
        write_reg(REG_DELTA_THRESHOLD, 13'd256);
        send_pixel(8'd0, 8'd255);
        settle();
        write_reg(REG_DELTA_THRESHOLD, 13'h1FFF);
        send_pixel(8'd255, 8'd0);
        settle();
        write_reg(REG_UNMAPPED, 13'd0);
        send_pixel(8'd0, 8'd255);
    endtask

    task automatic test_roi_window();
        int i;
        settle();
        configure(13'd10, 13'd4, 13'd3, 13'd1, 13'd1, 13'd2, 13'd1);
        for (i = 0; i < 12; i++)
        begin
            if (i % 2 == 0)
                send_pixel(8'd50, 8'd70);
            else
                send_pixel(8'd90, 8'd20);
        end
    endtask

    task automatic test_random_frames(input int budget);
        int sent, n;
        sent = 0;
        while (sent < budget)
        begin
            settle();
            randomize_config();
            n = pixels_to_frame_end();
            // stop part way so the next setting lands mid-frame
            if ($urandom_range(7) == 0)
                n = $urandom_range(1, n);
            repeat (n) send_random_pixel();
            sent += n;
        end
    endtask

    task automatic test_input_backpressure();
        settle();
        configure(13'd20, 13'd5, 13'd4, 13'd0, 13'd0, 13'd0, 13'd0);
        hold_request <= 1'b1;
        repeat (40) send_random_pixel();
    endtask

    // oversized frame and roi clamp, frames closed early by a smaller size
    task automatic test_largest_frames();
        settle();
        configure(13'd0, 13'h1FFF, 13'd1, 13'd20, 13'd0, 13'h1FFF, 13'd1);
        repeat (40) send_random_pixel();
        settle();
        write_reg(REG_FRAME_WIDTH, 13'd41);
        send_random_pixel();
        settle();
        configure(13'd200, 13'd1, 13'h1FFF, 13'd0, 13'd10, 13'd1, 13'h1FFF);
        repeat (40) send_random_pixel();
        settle();
        write_reg(REG_FRAME_HEIGHT, 13'd41);
        send_random_pixel();
    endtask

    initial
    begin
        reset_model();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 10;
        recv_stall_pct = 75;
        test_reset_defaults();
        test_threshold_extremes();
        test_roi_window();
        test_input_backpressure();
        test_random_frames(420);

        settle();
        send_idle_pct = 75;
        recv_stall_pct = 10;
        test_random_frames(420);

        settle();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_random_frames(420);
        test_largest_frames();

        settle();
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
